### rtl/core/blup_pkg.sv
// shared types, constants and helper functions of the 2x bilinear upsampler
// no dependencies; imported by every module of the block except blup_ram
`timescale 1ns / 1ps

package blup_pkg;

  // sizing of the map store
  localparam int MAX_SIDE    = 32;
  localparam int MAX_PAIRS   = 16;
  localparam int STORE_DEPTH = MAX_PAIRS * MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // field widths
  localparam int SIDE_W   = 6;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int PAIR_W   = 4;
  localparam int SAMPLE_W = 16;
  localparam int NUM_LANES = 2;
  localparam int WORD_W   = SAMPLE_W * NUM_LANES;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 32;

  // arithmetic
  localparam int NUM_TAPS = 4;
  localparam int WT_W     = 5;
  localparam int ACC_W    = SAMPLE_W + WT_W;
  localparam int FRAC_SH  = 4;
  localparam int YOFF_W   = COORD_W + SIDE_W;
  localparam int PS_W     = PAIR_W + SIDE_W;
  localparam int BASE_W   = PS_W + SIDE_W;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // side register reset
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // axis weights of the high neighbour, in quarters
  localparam logic [1:0] W_NONE   = 2'd0;
  localparam logic [1:0] W_QUART  = 2'd1;
  localparam logic [1:0] W_THREEQ = 2'd3;
  localparam logic [2:0] QUARTERS = 3'd4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [WT_W-1:0]            wt_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [WORD_W-1:0]          word_t;

  // read item control that travels with the store access
  typedef struct packed {
    logic                   valid;
    logic                   err;
    wt_t [NUM_TAPS-1:0]     wt;
  } blup_ctl_t;

  typedef struct packed {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic [1:0]         w;
  } blup_axis_t;

  typedef struct packed {
    logic    err;
    sample_t odd;
    sample_t even;
  } blup_res_t;

  // half-pixel-center mapping of one output coordinate onto the input grid
  function automatic blup_axis_t axis_map(input logic [SIDE_W-1:0] o,
                                          input logic [SIDE_W-1:0] side);
    blup_axis_t         a;
    logic [COORD_W-1:0] m;
    logic [SIDE_W-1:0]  nxt;
    m = o[COORD_W:1];
    if (o[0]) begin
      a.lo = m;
      a.w  = W_QUART;
    end else if (m == '0) begin
      a.lo = '0;
      a.w  = W_NONE;
    end else begin
      a.lo = m - 1'b1;
      a.w  = W_THREEQ;
    end
    nxt  = SIDE_W'(a.lo) + 1'b1;
    a.hi = (nxt < side) ? COORD_W'(nxt) : COORD_W'(side - 1'b1);
    return a;
  endfunction

  // product of two axis factors, in sixteenths
  function automatic wt_t tap_wt(input logic [2:0] a, input logic [2:0] b);
    wt_t pa;
    wt_t pb;
    pa = WT_W'(a);
    pb = WT_W'(b);
    return pa * pb;
  endfunction

endpackage

### rtl/core/blup_ram.sv
// generic single-write, dual-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module blup_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### rtl/core/blup_addr.sv
// request decode: range checks, axis mapping, weights and store addresses
// depends on blup_pkg; two register stages
`timescale 1ns / 1ps

module blup_addr
  import blup_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [SIDE_W-1:0]     side_cfg_i,
  input  logic                  take_i,
  input  logic                  req_type_i,
  input  logic [PAIR_W-1:0]     pair_i,
  input  logic [SIDE_W-1:0]     row_i,
  input  logic [SIDE_W-1:0]     col_i,
  input  word_t                 word_i,
  output logic                  we_o,
  output addr_t                 waddr_o,
  output word_t                 wdata_o,
  output addr_t [NUM_TAPS-1:0]  raddr_o,
  output blup_ctl_t             ctl_o
);

  // stage 0: decode at the input
  logic [SIDE_W-1:0]  side_eff;
  logic [SIDE_W:0]    side2;
  logic               pair_ok;
  logic               rd_err;
  logic               wr_ok;
  blup_axis_t         ax_y;
  blup_axis_t         ax_x;
  logic [COORD_W-1:0] y0, y1, x0, x1;
  logic [1:0]         wy, wx;
  logic [PS_W-1:0]    ps_d;
  logic [YOFF_W-1:0]  yoff0_d, yoff1_d;

  always_comb begin
    if (side_cfg_i == '0) begin
      side_eff = SIDE_W'(1);
    end else if (side_cfg_i > SIDE_W'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = side_cfg_i;
    end
  end

  assign side2   = {side_eff, 1'b0};
  assign pair_ok = (32'(pair_i) < MAX_PAIRS);
  assign rd_err  = ({1'b0, row_i} >= side2) || ({1'b0, col_i} >= side2) || !pair_ok;
  assign wr_ok   = (row_i < side_eff) && (col_i < side_eff) && pair_ok;
  assign ax_y    = axis_map(row_i, side_eff);
  assign ax_x    = axis_map(col_i, side_eff);

  always_comb begin
    if (req_type_i == REQ_READ) begin
      y0 = ax_y.lo;
      y1 = ax_y.hi;
      x0 = ax_x.lo;
      x1 = ax_x.hi;
      wy = ax_y.w;
      wx = ax_x.w;
    end else begin
      y0 = row_i[COORD_W-1:0];
      y1 = row_i[COORD_W-1:0];
      x0 = col_i[COORD_W-1:0];
      x1 = col_i[COORD_W-1:0];
      wy = W_NONE;
      wx = W_NONE;
    end
  end

  assign ps_d    = PS_W'(pair_i) * PS_W'(side_eff);
  assign yoff0_d = YOFF_W'(y0) * YOFF_W'(side_eff);
  assign yoff1_d = YOFF_W'(y1) * YOFF_W'(side_eff);

  // stage 1 registers
  logic               s1_vld_q;
  logic               s1_rd_q, s1_err_q, s1_wok_q;
  logic [SIDE_W-1:0]  s1_side_q;
  logic [PS_W-1:0]    s1_ps_q;
  logic [YOFF_W-1:0]  s1_yoff0_q, s1_yoff1_q;
  logic [COORD_W-1:0] s1_x0_q, s1_x1_q;
  logic [1:0]         s1_wy_q, s1_wx_q;
  word_t              s1_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_rd_q    <= (req_type_i == REQ_READ);
    s1_err_q   <= rd_err;
    s1_wok_q   <= wr_ok;
    s1_side_q  <= side_eff;
    s1_ps_q    <= ps_d;
    s1_yoff0_q <= yoff0_d;
    s1_yoff1_q <= yoff1_d;
    s1_x0_q    <= x0;
    s1_x1_q    <= x1;
    s1_wy_q    <= wy;
    s1_wx_q    <= wx;
    s1_word_q  <= word_i;
  end

  // stage 1: pair base, tap addresses and weights
  logic [BASE_W-1:0]    base_full;
  addr_t                base;
  addr_t                row0, row1;
  addr_t [NUM_TAPS-1:0] raddr_d;
  wt_t [NUM_TAPS-1:0]   wt_d;
  logic [2:0]           fy_lo, fy_hi, fx_lo, fx_hi;

  assign base_full = BASE_W'(s1_ps_q) * BASE_W'(s1_side_q);
  assign base      = base_full[ADDR_W-1:0];
  assign row0      = base + ADDR_W'(s1_yoff0_q);
  assign row1      = base + ADDR_W'(s1_yoff1_q);
  assign raddr_d[0] = row0 + ADDR_W'(s1_x0_q);
  assign raddr_d[1] = row0 + ADDR_W'(s1_x1_q);
  assign raddr_d[2] = row1 + ADDR_W'(s1_x0_q);
  assign raddr_d[3] = row1 + ADDR_W'(s1_x1_q);

  assign fy_hi = {1'b0, s1_wy_q};
  assign fx_hi = {1'b0, s1_wx_q};
  assign fy_lo = QUARTERS - fy_hi;
  assign fx_lo = QUARTERS - fx_hi;
  assign wt_d[0] = tap_wt(fy_lo, fx_lo);
  assign wt_d[1] = tap_wt(fy_lo, fx_hi);
  assign wt_d[2] = tap_wt(fy_hi, fx_lo);
  assign wt_d[3] = tap_wt(fy_hi, fx_hi);

  // stage 2 registers
  logic                 we_q;
  logic                 rd_vld_q;
  logic                 err_q;
  addr_t [NUM_TAPS-1:0] raddr_q;
  word_t                wdata_q;
  wt_t [NUM_TAPS-1:0]   wt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      we_q     <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      we_q     <= s1_vld_q && !s1_rd_q && s1_wok_q;
      rd_vld_q <= s1_vld_q && s1_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q   <= s1_err_q;
    raddr_q <= raddr_d;
    wdata_q <= s1_word_q;
    wt_q    <= wt_d;
  end

  assign we_o    = we_q;
  assign waddr_o = raddr_q[0];
  assign wdata_o = wdata_q;
  assign raddr_o = raddr_q;
  assign ctl_o   = '{valid: rd_vld_q, err: err_q, wt: wt_q};

endmodule

### rtl/core/blup_lane.sv
// one channel lane: weighted sum of four neighbor samples in sixteenths
// depends on blup_pkg
`timescale 1ns / 1ps

module blup_lane
  import blup_pkg::*;
(
  input  logic                   clk_i,
  input  sample_t [NUM_TAPS-1:0] samp_i,
  input  wt_t [NUM_TAPS-1:0]     wt_i,
  output acc_t                   acc_o
);

  acc_t prod [NUM_TAPS];
  acc_t acc_d;
  acc_t acc_q;

  always_comb begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      prod[k] = ACC_W'($signed({1'b0, wt_i[k]}) * $signed(samp_i[k]));
    end
    acc_d = (prod[0] + prod[1]) + (prod[2] + prod[3]);
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

### rtl/core/blup_merge.sv
// merges lane sums into a result item: rounding, error zeroing, result queue
// depends on blup_pkg; also tracks results owed so the input never overruns the queue
`timescale 1ns / 1ps

module blup_merge
  import blup_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  blup_ctl_t             ctl_i,
  input  acc_t [NUM_LANES-1:0]  acc_i,
  input  logic                  take_rd_i,
  output logic                  space_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output blup_res_t             res_o
);

  logic vld_q;
  logic err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= ctl_i.err;
  end

  // round half up: add half an lsb, floor shift by four
  sample_t   rnd [NUM_LANES];
  acc_t      biased [NUM_LANES];
  blup_res_t push_res;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      biased[l] = acc_i[l] + ACC_W'(8);
      rnd[l]    = biased[l][FRAC_SH +: SAMPLE_W];
    end
    if (err_q) begin
      push_res = '0;
      push_res.err = 1'b1;
    end else begin
      push_res.err  = 1'b0;
      push_res.even = rnd[0];
      push_res.odd  = rnd[1];
    end
  end

  // result queue
  blup_res_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   owed_q, owed_d;
  logic               pop;

  assign m_tvalid_o = (cnt_q != '0);
  assign pop        = m_tvalid_o && m_tready_i;
  assign res_o      = mem_q[rd_ptr_q];
  assign space_o    = (owed_q < CNT_W'(FIFO_DEPTH));

  always_comb begin
    cnt_d  = cnt_q + CNT_W'(vld_q) - CNT_W'(pop);
    owed_d = owed_q + CNT_W'(take_rd_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      owed_q   <= '0;
    end else begin
      cnt_q  <= cnt_d;
      owed_q <= owed_d;
      if (vld_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      mem_q[wr_ptr_q] <= push_res;
    end
  end

endmodule

### rtl/core/bilinear_upsample_x2.sv
// top level of the 2x bilinear upsampler (align corners false, quarter weights)
// depends on blup_pkg, blup_addr, blup_ram, blup_lane and blup_merge
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid / tready         tdata: pair_index, row, col, sample_even,
//                                          sample_odd; tuser: req_type
//   m_axis    out  tvalid / tready         tdata: pixel_even, pixel_odd;
//                                          tuser: range_error
//   cfg       in   cfg_we_i (no wait)      cfg_wdata_i: in_side
//
// one item per cycle is accepted while s_axis tready is high; a read item comes out
// after the two decode stages, the registered store read, the lane sums and the
// result queue, and a write item lands in the store after the two decode stages.
// reset clears the control state only; the store is not cleared and holds
// whatever was written. stalls on m_axis fill an 8-entry result queue; s_axis
// tready drops once 8 read items are owed to m_axis and comes back as they drain.
`timescale 1ns / 1ps

module bilinear_upsample_x2
  import blup_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config: in_side
  input  logic                 cfg_we_i,
  input  logic [SIDE_W-1:0]    cfg_wdata_i,
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [3:0] pair_index, [9:4] row, [15:10] col, [31:16] sample_even, [47:32] sample_odd
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] req_type
  input  logic                 s_axis_tuser,
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] pixel_even, [31:16] pixel_odd
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [0] range_error
  output logic                 m_axis_tuser
);

  // side length register
  logic [SIDE_W-1:0] side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_RESET;
    end else if (cfg_we_i) begin
      side_q <= cfg_wdata_i;
    end
  end

  // input item fields
  logic [PAIR_W-1:0] pair_index;
  logic [SIDE_W-1:0] row, col;
  word_t             in_word;
  logic              take;
  logic              take_rd;
  logic              space;

  assign pair_index = s_axis_tdata[3:0];
  assign row        = s_axis_tdata[9:4];
  assign col        = s_axis_tdata[15:10];
  // even sample in the low half, odd in the high half, as stored
  assign in_word    = s_axis_tdata[47:16];

  assign s_axis_tready = space;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign take_rd       = take && (s_axis_tuser == REQ_READ);

  // decode and address generation
  logic                 we;
  addr_t                waddr;
  word_t                wdata;
  addr_t [NUM_TAPS-1:0] raddr;
  blup_ctl_t            ctl2;

  blup_addr u_addr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .side_cfg_i (side_q),
    .take_i     (take),
    .req_type_i (s_axis_tuser),
    .pair_i     (pair_index),
    .row_i      (row),
    .col_i      (col),
    .word_i     (in_word),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .ctl_o      (ctl2)
  );

  // two copies of the map store, written together; each serves two of the
  // four neighbors so all taps are read in the same cycle
  word_t tap_word [NUM_TAPS];

  blup_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_top (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr[0]),
    .raddr_b_i (raddr[1]),
    .rdata_a_o (tap_word[0]),
    .rdata_b_o (tap_word[1])
  );

  blup_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_bot (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr[2]),
    .raddr_b_i (raddr[3]),
    .rdata_a_o (tap_word[2]),
    .rdata_b_o (tap_word[3])
  );

  // control is registered once to line up with the registered store read
  logic      ctl3_vld_q;
  blup_ctl_t ctl3_q;
  blup_ctl_t ctl3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_vld_q <= 1'b0;
    end else begin
      ctl3_vld_q <= ctl2.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl3_q <= ctl2;
  end

  assign ctl3 = '{valid: ctl3_vld_q, err: ctl3_q.err, wt: ctl3_q.wt};

  // one lane per channel of the pair
  acc_t [NUM_LANES-1:0] lane_acc;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    sample_t [NUM_TAPS-1:0] samp;
    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
      assign samp[k] = tap_word[k][SAMPLE_W*l +: SAMPLE_W];
    end
    blup_lane u_lane (
      .clk_i  (clk_i),
      .samp_i (samp),
      .wt_i   (ctl3.wt),
      .acc_o  (lane_acc[l])
    );
  end

  // rounding, error zeroing and the result queue
  blup_res_t res;

  blup_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl3),
    .acc_i      (lane_acc),
    .take_rd_i  (take_rd),
    .space_o    (space),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {res.odd, res.even};
  assign m_axis_tuser = res.err;

endmodule

### rtl/core/blup_chk.sv
// port-level checks of the 2x bilinear upsampler, bound to the top level
// depends on blup_pkg and bilinear_upsample_x2
`timescale 1ns / 1ps

module blup_chk
  import blup_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an out-of-range result carries zero pixels
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("range error with nonzero pixels");

  // input back-pressure only while results wait
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // a result appearing on an empty output follows a read item taken through the full read pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_READ, 5))
    else $error("result without a matching read item");

endmodule

bind bilinear_upsample_x2 blup_chk u_chk (.*);

### bench/tb_bilinear_upsample_x2.sv
// self-checking testbench for the 2x bilinear upsampler, top level bilinear_upsample_x2
// depends on blup_pkg and the rtl of the block; a built-in model predicts every result item
`timescale 1ns / 1ps

module tb_bilinear_upsample_x2;
  import blup_pkg::*;

  // input item payload as it sits on s_axis_tdata, lowest field last
  typedef struct packed {
    sample_t             odd;
    sample_t             even;
    logic [SIDE_W-1:0]   col;
    logic [SIDE_W-1:0]   row;
    logic [PAIR_W-1:0]   pair;
  } pix_req_t;

  // longest stretch without any handshake before the run is declared hung
  localparam int unsigned QUIET_LIMIT  = 2000;
  // cycles for a write item to land in the store once everything is out
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam int unsigned NUM_PHASES   = 9;

  // mirror of the map store plus the queue of pixels still owed by the block
  class pixel_scoreboard;
    word_t             map_words   [STORE_DEPTH];
    bit                map_written [STORE_DEPTH];
    logic [SIDE_W-1:0] side_reg = SIDE_RESET;
    blup_res_t         owed_pixels [$];
    int unsigned       errors = 0;

    // side as the block uses it: zero acts as one, large values saturate
    function int unsigned side_now();
      if (side_reg == '0) return 1;
      if (side_reg > MAX_SIDE) return MAX_SIDE;
      return side_reg;
    endfunction

    function int unsigned slot(int unsigned p, int unsigned r, int unsigned c);
      int unsigned s;
      s = side_now();
      return p * s * s + r * s + c;
    endfunction

    // output coordinate -> low/high input neighbour and high weight in quarters
    function void axis(input int unsigned o, output int unsigned lo, output int unsigned hi,
                       output int unsigned wq);
      int unsigned s;
      int unsigned m;
      s = side_now();
      m = o / 2;
      if (o % 2) begin
        lo = m;
        wq = W_QUART;
      end else if (m == 0) begin
        lo = 0;
        wq = W_NONE;
      end else begin
        lo = m - 1;
        wq = W_THREEQ;
      end
      hi = (lo + 1 < s) ? lo + 1 : s - 1;
    endfunction

    // bilinear mix of four stored words, exact in sixteenths, rounded half up
    function blup_res_t interp_pixel(pix_req_t q);
      blup_res_t   res;
      int unsigned y0, y1, wy, x0, x1, wx, s;
      int unsigned tap_addr [NUM_TAPS];
      int          tap_wt   [NUM_TAPS];
      word_t       w;
      sample_t     smp;
      int          acc;
      s   = side_now();
      res = '0;
      if (q.row >= 2 * s || q.col >= 2 * s) begin
        res.err = 1'b1;
        return res;
      end
      axis(q.row, y0, y1, wy);
      axis(q.col, x0, x1, wx);
      tap_addr[0] = slot(q.pair, y0, x0);
      tap_addr[1] = slot(q.pair, y0, x1);
      tap_addr[2] = slot(q.pair, y1, x0);
      tap_addr[3] = slot(q.pair, y1, x1);
      tap_wt[0]   = (QUARTERS - wy) * (QUARTERS - wx);
      tap_wt[1]   = (QUARTERS - wy) * wx;
      tap_wt[2]   = wy * (QUARTERS - wx);
      tap_wt[3]   = wy * wx;
      for (int lane = 0; lane < NUM_LANES; lane++) begin
        acc = 0;
        for (int k = 0; k < NUM_TAPS; k++) begin
          w   = map_words[tap_addr[k]];
          smp = (lane == 0) ? w[SAMPLE_W-1:0] : w[WORD_W-1:SAMPLE_W];
          acc += tap_wt[k] * smp;
        end
        // bias by half a unit, then arithmetic shift floors
        if (lane == 0) res.even = SAMPLE_W'((acc + 8) >>> FRAC_SH);
        else           res.odd  = SAMPLE_W'((acc + 8) >>> FRAC_SH);
      end
      return res;
    endfunction

    // accepted input item: update the store or queue the owed pixel
    function void take_request(logic kind, pix_req_t q);
      int unsigned s;
      int unsigned a;
      s = side_now();
      if (kind == REQ_WRITE) begin
        if (q.row < s && q.col < s) begin
          a              = slot(q.pair, q.row, q.col);
          map_words[a]   = {q.odd, q.even};
          map_written[a] = 1'b1;
        end
      end else begin
        owed_pixels.push_back(interp_pixel(q));
      end
    endfunction

    // accepted result item against the oldest owed pixel
    function void check_pixel(blup_res_t got);
      blup_res_t want;
      if (owed_pixels.size() == 0) begin
        $error("unexpected result item: pixel_even %0d pixel_odd %0d range_error %0b",
               got.even, got.odd, got.err);
        errors++;
        return;
      end
      want = owed_pixels.pop_front();
      if (got.even !== want.even) begin
        $error("pixel_even: expected %0d, got %0d", want.even, got.even);
        errors++;
      end
      if (got.odd !== want.odd) begin
        $error("pixel_odd: expected %0d, got %0d", want.odd, got.odd);
        errors++;
      end
      if (got.err !== want.err) begin
        $error("range_error: expected %0b, got %0b", want.err, got.err);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [SIDE_W-1:0]    cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // pair_index, row, col, sample_even, sample_odd
  logic                 s_axis_tuser;   // req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // pixel_even, pixel_odd
  logic                 m_axis_tuser;   // range_error

  pixel_scoreboard sb = new;

  // idling knobs, percent chance that a burst starts before an item or a cycle
  int unsigned tx_gap_pct   = 0;
  int unsigned rx_stall_pct = 0;
  // items that reach the block's state or output, dropped writes excluded
  int unsigned useful_items = 0;

  bilinear_upsample_x2 uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // both handshakes are observed at the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.take_request(s_axis_tuser, pix_req_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) sb.check_pixel(blup_res_t'({m_axis_tuser, m_axis_tdata}));
    end
  end

  // result side back-pressure: random stall bursts
  initial begin
    int unsigned hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        hold_left     = $urandom_range(1, 17) - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // hang detector: too long with no item moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_bilinear_upsample_x2: FAIL");
    $finish;
  end

  // random sample, leaning toward the extremes now and then
  function automatic sample_t rand_sample();
    logic [SAMPLE_W-1:0] v;
    v = SAMPLE_W'($urandom);
    case ($urandom_range(0, 7))
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2:       v = '0;
      3:       v = '1;
      default: ;
    endcase
    return v;
  endfunction

  // present one item, called just after a falling edge, returns after acceptance
  task automatic send(logic kind, int unsigned p, int unsigned r, int unsigned c,
                      sample_t ev, sample_t od);
    pix_req_t q;
    q.pair = PAIR_W'(p);
    q.row  = SIDE_W'(r);
    q.col  = SIDE_W'(c);
    q.even = ev;
    q.odd  = od;
    if (kind == REQ_READ || (r < sb.side_now() && c < sb.side_now())) useful_items++;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = q;
    s_axis_tuser  = kind;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // write a neighbour with random data unless it already holds a value
  task automatic fill_tap(int unsigned p, int unsigned y, int unsigned x);
    if (!sb.map_written[sb.slot(p, y, x)]) send(REQ_WRITE, p, y, x, rand_sample(), rand_sample());
  endtask

  // read of an upsampled pixel, preceded by writes of any neighbour never stored
  task automatic read_at(int unsigned p, int unsigned r, int unsigned c);
    int unsigned y0, y1, wy, x0, x1, wx;
    sb.axis(r, y0, y1, wy);
    sb.axis(c, x0, x1, wx);
    fill_tap(p, y0, x0);
    fill_tap(p, y0, x1);
    fill_tap(p, y1, x0);
    fill_tap(p, y1, x1);
    send(REQ_READ, p, r, c, rand_sample(), rand_sample());
  endtask

  // change the side only with nothing in flight
  task automatic set_side(logic [SIDE_W-1:0] v);
    s_axis_tvalid = 1'b0;
    while (sb.owed_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sb.side_reg = v;
  endtask

  // mostly fill-then-read sequences, plus off-map reads and writes and plain writes
  task automatic run_phase(int unsigned n);
    int unsigned s, p, r, c, t, pick, start;
    start = useful_items;
    while (useful_items - start < n) begin
      s    = sb.side_now();
      p    = $urandom_range(0, MAX_PAIRS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 12 && s < MAX_SIDE) begin
        // read beyond the upsampled map
        r = $urandom_range(0, 63);
        c = $urandom_range(2 * s, 63);
        if ($urandom_range(0, 1)) begin
          t = r;
          r = c;
          c = t;
        end
        send(REQ_READ, p, r, c, rand_sample(), rand_sample());
      end else if (pick < 20) begin
        // write off the input map, dropped by the block
        r = $urandom_range(s, 63);
        c = $urandom_range(0, 63);
        if ($urandom_range(0, 1)) begin
          t = r;
          r = c;
          c = t;
        end
        send(REQ_WRITE, p, r, c, rand_sample(), rand_sample());
      end else if (pick < 32) begin
        send(REQ_WRITE, p, $urandom_range(0, s - 1), $urandom_range(0, s - 1),
             rand_sample(), rand_sample());
      end else begin
        read_at(p, $urandom_range(0, 2 * s - 1), $urandom_range(0, 2 * s - 1));
      end
    end
  endtask

  initial begin
    int unsigned side_plan  [NUM_PHASES];
    int unsigned gap_plan   [NUM_PHASES];
    int unsigned stall_plan [NUM_PHASES];

    // side 0 acts as 1, 33 and 63 saturate; the last phase runs with no idling
    side_plan  = '{1, 0, 63, 2, 33, 5, 17, 0, 32};
    gap_plan   = '{20, 0, 35, 10, 50, 0, 5, 15, 0};
    stall_plan = '{10, 30, 0, 45, 20, 0, 60, 15, 0};
    side_plan[7] = $urandom_range(3, 31);

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_WRITE;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part at the reset side: full-scale samples near the origin
    tx_gap_pct   = 10;
    rx_stall_pct = 10;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        send(REQ_WRITE, 0, r, c, ((r + c) % 2) ? 16'h8000 : 16'h7FFF,
             ((r + c) % 2) ? 16'h7FFF : 16'h8000);
      end
    end
    // far corner of the last pair, then a write at the top coordinates that is dropped
    send(REQ_WRITE, MAX_PAIRS - 1, 31, 31, 16'hFFFF, 16'h0001);
    send(REQ_WRITE, MAX_PAIRS - 1, 31, 30, 16'h7FFF, 16'hFFFF);
    send(REQ_WRITE, MAX_PAIRS - 1, 30, 31, 16'h0000, 16'h8000);
    send(REQ_WRITE, MAX_PAIRS - 1, 30, 30, 16'h0001, 16'h7FFF);
    send(REQ_WRITE, MAX_PAIRS - 1, 63, 63, 16'hFFFF, 16'hFFFF);
    // zero weight at the origin, quarter and three-quarter weights
    read_at(0, 0, 0);
    read_at(0, 1, 1);
    read_at(0, 2, 2);
    read_at(0, 1, 2);
    read_at(0, 3, 4);
    read_at(0, 4, 3);
    // far edge where the high neighbour clamps to the last row and column
    read_at(MAX_PAIRS - 1, 63, 63);
    read_at(MAX_PAIRS - 1, 62, 62);
    read_at(MAX_PAIRS - 1, 61, 61);

    // random phases, each under its own side and idling mix
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_side(SIDE_W'(side_plan[ph]));
      tx_gap_pct   = gap_plan[ph];
      rx_stall_pct = stall_plan[ph];
      run_phase(PHASE_ITEMS);
    end

    s_axis_tvalid = 1'b0;
    while (sb.owed_pixels.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sb.errors == 0 && sb.owed_pixels.size() == 0) begin
      $display("tb_bilinear_upsample_x2: PASS");
    end else begin
      $display("tb_bilinear_upsample_x2: FAIL");
    end
    $finish;
  end

endmodule
